FILE: hw/rtl/bb3_pkg.sv
// ---------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 binomial blur stream unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int SAMPLE_BITS   = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int SUM_BITS      = SAMPLE_BITS + 2;
    localparam int ACC_BITS      = SAMPLE_BITS + 5;
    localparam int WIDTH_BITS    = 12;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int WIDTH_RESET   = 2048;
    localparam int HEIGHT_RESET  = 1;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_DRAIN  = 1'b1;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] older;
        logic signed [SUM_BITS-1:0] newer;
    } line_entry_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          last_pixel;
        logic                          last_of_step;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // last column index for a raw width write: zero acts as one, large widths saturate
    function automatic logic [COL_BITS-1:0] width_last(int unsigned raw);
        int unsigned w;
        w = raw;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > MAX_WIDTH)
        begin
            w = MAX_WIDTH;
        end
        return COL_BITS'(w - 1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/binomial_blur_3x3_stream_unit.sv
// ---------------------------------------------------------------------------
// binomial_blur_3x3_stream_unit
// Separable [1 2 1] blur of a raster pixel stream, rounded once per pixel.
// ---------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets image_width and
//   image_height; any write restarts the image. cfg_ready is always high.
//   in channel carries one item per handshake: a pixel (action 0) or a drain
//   request (action 1). Row y comes out while row y+1 arrives; after the last
//   row, one drain item returns one pixel of that row. Images below 3x3 pass
//   pixels through unchanged.
//   out channel returns value, last_pixel and last_of_step.
// Throughput: a result is written into the result queue when its item is
//   taken. One item per cycle; the item closing a row after the first gives
//   two results. in_ready is set by a four-entry result queue and drops
//   while fewer than two entries are free.
// Reset: width 2048, height 1, stream position cleared, queue empty. The line
//   stores are not cleared; every entry is written before it is used.
// Stall: results collect in the queue while out_ready is low; the input stops
//   once the queue cannot hold another two results.
// ---------------------------------------------------------------------------
`default_nettype none

module binomial_blur_3x3_stream_unit
    import bb3_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          action,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      value,
    output logic                               last_pixel,
    output logic                               last_of_step,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    function automatic logic signed [ACC_BITS-1:0] vert_sum(
        line_entry_t e, logic signed [SUM_BITS-1:0] h, logic top_row);
        logic signed [ACC_BITS-1:0] o;
        logic signed [ACC_BITS-1:0] n;
        logic signed [ACC_BITS-1:0] hh;
        o  = ACC_BITS'(e.older);
        n  = ACC_BITS'(e.newer);
        hh = ACC_BITS'(h);
        if (top_row)
        begin
            return n + (n <<< 1) + hh;
        end
        return o + (n <<< 1) + hh;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] round_out(
        logic signed [ACC_BITS-1:0] acc);
        logic signed [ACC_BITS-1:0] t;
        t = acc + ACC_BITS'(8);
        return t[SAMPLE_BITS+3:4];
    endfunction

    logic [COL_BITS-1:0]           wm1_reg,    wm1_next;
    logic [HEIGHT_BITS-1:0]        height_reg, height_next;
    logic [COL_BITS-1:0]           col_reg,    col_next;
    logic [HEIGHT_BITS-1:0]        row_reg,    row_next;
    logic [COL_BITS-1:0]           drain_reg,  drain_next;
    logic signed [SAMPLE_BITS-1:0] left_reg,   left_next;
    logic signed [SAMPLE_BITS-1:0] mid_reg,    mid_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [COL_BITS-1:0]           pend_addr_reg;
    line_entry_t                   pend_data_reg;

    logic in_fire;
    logic cfg_fire;
    logic is_small;
    logic col_end;
    logic row_done;
    logic has_left;
    logic img_end;
    logic do_pix;
    logic do_drain;
    logic do_pass;

    logic signed [SUM_BITS-1:0] cur_s;
    logic signed [SUM_BITS-1:0] mid_s;
    logic signed [SUM_BITS-1:0] left_s;
    logic signed [SUM_BITS-1:0] hs_a;
    logic signed [SUM_BITS-1:0] hs_b;
    logic signed [ACC_BITS-1:0] drain_acc;

    line_entry_t         rd_a;
    line_entry_t         rd_b;
    logic                rd_en;
    logic [COL_BITS-1:0] rd_addr_a;
    logic [COL_BITS-1:0] rd_addr_b;
    logic                st_wr;
    logic                wr_en;
    logic [COL_BITS-1:0] wr_addr;
    line_entry_t         wr_data;
    line_entry_t         step_data;
    line_entry_t         end_data;

    result_t res_a;
    result_t res_b;
    result_t res_d;
    result_t res_p;
    push_t   push;
    result_t head;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        is_small = (wm1_reg < COL_BITS'(2)) || (height_reg < HEIGHT_BITS'(3));
        col_end  = col_reg == wm1_reg;
        row_done = row_reg >= height_reg;
        has_left = col_reg != '0;
        img_end  = ((HEIGHT_BITS + 1)'(row_reg) + (HEIGHT_BITS + 1)'(1))
                   == (HEIGHT_BITS + 1)'(height_reg);
        do_pix   = in_fire && (action == ACTION_SAMPLE) && !is_small && !row_done;
        do_pass  = in_fire && (action == ACTION_SAMPLE) && is_small;
        do_drain = in_fire && (action == ACTION_DRAIN) && !is_small && row_done;
    end

    // horizontal sums; the row edge weighs the edge pixel three times
    always_comb
    begin
        cur_s  = SUM_BITS'(sample);
        mid_s  = SUM_BITS'(mid_reg);
        left_s = SUM_BITS'(left_reg);
        if (col_reg == COL_BITS'(1))
        begin
            hs_a = mid_s + (mid_s <<< 1) + cur_s;
        end
        else
        begin
            hs_a = left_s + (mid_s <<< 1) + cur_s;
        end
        hs_b      = cur_s + (cur_s <<< 1) + mid_s;
        drain_acc = ACC_BITS'(rd_a.older) + ACC_BITS'(rd_a.newer)
                    + (ACC_BITS'(rd_a.newer) <<< 1);
    end

    always_comb
    begin
        res_a.value        = round_out(vert_sum(rd_a, hs_a, row_reg == HEIGHT_BITS'(1)));
        res_a.last_pixel   = 1'b0;
        res_a.last_of_step = !col_end;
        res_b.value        = round_out(vert_sum(rd_b, hs_b, row_reg == HEIGHT_BITS'(1)));
        res_b.last_pixel   = 1'b0;
        res_b.last_of_step = 1'b1;
        res_d.value        = round_out(drain_acc);
        res_d.last_pixel   = drain_reg == wm1_reg;
        res_d.last_of_step = 1'b1;
        res_p.value        = sample;
        res_p.last_pixel   = col_end && img_end;
        res_p.last_of_step = 1'b1;
    end

    always_comb
    begin
        push.count  = 2'd0;
        push.first  = res_a;
        push.second = res_b;
        priority if (do_pix)
        begin
            if (row_reg != '0 && has_left)
            begin
                push.count = col_end ? 2'd2 : 2'd1;
            end
        end
        else if (do_drain)
        begin
            push.count = 2'd1;
            push.first = res_d;
        end
        else if (do_pass)
        begin
            push.count = 2'd1;
            push.first = res_p;
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    // prefetch the entries the next item needs; the row end prefetches column 0
    always_comb
    begin
        rd_en     = do_pix || do_drain;
        rd_addr_b = col_reg + COL_BITS'(1);
        if (do_drain)
        begin
            rd_addr_a = drain_reg + COL_BITS'(1);
        end
        else if (col_end)
        begin
            rd_addr_a = '0;
        end
        else
        begin
            rd_addr_a = col_reg;
        end
    end

    // the second write of a row end is registered and goes out in the following cycle
    always_comb
    begin
        st_wr           = do_pix && has_left;
        step_data.older = rd_a.newer;
        step_data.newer = hs_a;
        end_data.older  = rd_b.newer;
        end_data.newer  = hs_b;
        pend_valid_next = do_pix && col_end;
        wr_en           = pend_valid_reg || st_wr;
        if (pend_valid_reg)
        begin
            wr_addr = pend_addr_reg;
            wr_data = pend_data_reg;
        end
        else
        begin
            wr_addr = col_reg - COL_BITS'(1);
            wr_data = step_data;
        end
    end

    always_comb
    begin
        wm1_next    = wm1_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        left_next   = left_reg;
        mid_next    = mid_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    wm1_next = width_last(int'(cfg_data[WIDTH_BITS-1:0]));
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = (cfg_data[HEIGHT_BITS-1:0] == '0) ? HEIGHT_BITS'(1)
                                                                    : cfg_data[HEIGHT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
            left_next  = '0;
            mid_next   = '0;
        end
        else if (do_pass)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = img_end ? '0 : row_reg + HEIGHT_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
        else if (do_pix)
        begin
            if (col_end)
            begin
                col_next  = '0;
                row_next  = row_reg + HEIGHT_BITS'(1);
                left_next = '0;
                mid_next  = '0;
            end
            else
            begin
                col_next  = col_reg + COL_BITS'(1);
                left_next = mid_reg;
                mid_next  = sample;
            end
        end
        else if (do_drain)
        begin
            if (drain_reg == wm1_reg)
            begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
                left_next  = '0;
                mid_next   = '0;
            end
            else
            begin
                drain_next = drain_reg + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg        <= width_last(WIDTH_RESET);
            height_reg     <= HEIGHT_BITS'(HEIGHT_RESET);
            col_reg        <= '0;
            row_reg        <= '0;
            drain_reg      <= '0;
            left_reg       <= '0;
            mid_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            wm1_reg        <= wm1_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            drain_reg      <= drain_next;
            left_reg       <= left_next;
            mid_reg        <= mid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_next)
        begin
            pend_addr_reg <= col_reg;
            pend_data_reg <= end_data;
        end
    end

    bb3_line_store u_line_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    bb3_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign value        = head.value;
    assign last_pixel   = head.last_pixel;
    assign last_of_step = head.last_of_step;

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_line_store.sv
// ---------------------------------------------------------------------------
// bb3_line_store
// Line store holding the horizontal sums of the two previous rows per column.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_line_store
    import bb3_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire logic [COL_BITS-1:0] rd_addr_a,
    input  wire logic [COL_BITS-1:0] rd_addr_b,
    output line_entry_t              rd_data_a,
    output line_entry_t              rd_data_b,
    input  wire logic                wr_en,
    input  wire logic [COL_BITS-1:0] wr_addr,
    input  line_entry_t              wr_data
);

    line_entry_t mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_result_queue.sv
// ---------------------------------------------------------------------------
// bb3_result_queue
// Small result queue: takes up to two results per cycle, hands out one while out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_result_queue
    import bb3_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  push_t     push,
    output logic      room,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   head
);

    result_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 pop;

    // room for a full two-result item
    assign room      = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign head      = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        count_next  = count_reg + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr_reg + QPTR_BITS'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_checker.sv
// ---------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the blur stream unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_checker
    import bb3_pkg::*;
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          action,
    input wire logic signed [SAMPLE_BITS-1:0] sample,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] value,
    input wire logic                          last_pixel,
    input wire logic                          last_of_step,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [CFG_IDX_BITS-1:0]       cfg_index,
    input wire logic [CFG_DATA_BITS-1:0]      cfg_data
);

    // nothing to show once reset has taken hold
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result shown during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(value) && $stable(last_pixel) && $stable(last_of_step))
        else $error("stalled result changed");

    a_last_pixel_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |-> last_of_step)
        else $error("last pixel not last of its item");

    // an empty queue always has room for a full item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // the second result of a row end is already queued behind the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_step |=> out_valid)
        else $error("second result of an item missing");

endmodule

bind binomial_blur_3x3_stream_unit bb3_checker u_bb3_checker (.*);

`default_nettype wire
